@@ design/masked_width_integer_alu_top_assert.svh @@
// assertion macros shared by the alu modules
// needs only the clock and active-low reset names passed in by the caller
`ifndef MASKED_WIDTH_INTEGER_ALU_TOP_ASSERT_SVH
`define MASKED_WIDTH_INTEGER_ALU_TOP_ASSERT_SVH

// same-cycle implication
`define MWALU_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MWALU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mwalu_pkg.sv @@
// shared types and constants of the masked width alu
// no dependencies
package mwalu_pkg;

    localparam int DATA_W = 64;
    localparam int WID_W  = 7;
    localparam int HALF_W = DATA_W / 2;

    typedef enum logic [3:0] {
        OP_NOT  = 4'd0,
        OP_NEG  = 4'd1,
        OP_AND  = 4'd2,
        OP_OR   = 4'd3,
        OP_XOR  = 4'd4,
        OP_ADD  = 4'd5,
        OP_MUL  = 4'd6,
        OP_SUB  = 4'd7,
        OP_DIV  = 4'd8,
        OP_MOD  = 4'd9,
        OP_SHL  = 4'd10,
        OP_SHR  = 4'd11,
        OP_ROTL = 4'd12,
        OP_ROTR = 4'd13,
        OP_CH   = 4'd14,
        OP_MAJ  = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_MOD0 = 2'd2
    } status_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
        logic [DATA_W-1:0] mask;
        logic [WID_W-1:0]  w;
        logic              b_zero;
    } item_t;

endpackage

@@ design/masked_width_integer_alu_top.sv @@
// masked width integer alu, top level with input, divide and result stages
// uses mwalu_pkg and mwalu_divpipe
//
// usage:
//   items enter on s_tvalid/s_tready/s_tdata, results leave on m_tvalid/m_tready/m_tdata
//   cfg_we with cfg_wdata sets the active width (0 acts as 1, above MAX_WIDTH saturates);
//   write it only while no item is in flight
// latency: MAX_WIDTH + 3 cycles from accept to result (input register, one divide
//   stage per quotient bit, partial product stage, result register)
// throughput: one item per cycle; the restoring divider and the split multiplier
//   are fully pipelined, so every opcode takes the same path
// stall: the whole pipe holds while the result register is full and m_tready is low;
//   s_tready follows that, so nothing is dropped or repeated
// reset: all valid bits clear, width returns to MAX_WIDTH
// division or modulo by zero returns value 0 with a nonzero status
`include "masked_width_integer_alu_top_assert.svh"

module masked_width_integer_alu_top #(
    parameter int MAX_WIDTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,   // bit_width
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [199:0] s_tdata,     // req_type[3:0], operand_a, operand_b, operand_c, pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata      // result_value[63:0], status[65:64], pad
);

    localparam int DW = mwalu_pkg::DATA_W;
    localparam int CW = mwalu_pkg::WID_W;
    localparam int HW = mwalu_pkg::HALF_W;
    localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);

    logic          en;
    logic [CW-1:0] w_reg, w_next;
    logic [DW-1:0] mask_reg, mask_next;

    // width register with clamp and precomputed mask
    always_comb begin
        w_next = cfg_wdata;
        if (cfg_wdata == '0) begin
            w_next = CW'(1);
        end else if (cfg_wdata > MAXW) begin
            w_next = MAXW;
        end
        if (w_next == CW'(DW)) begin
            mask_next = '1;
        end else begin
            mask_next = (DW'(1) << w_next) - DW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg    <= MAXW;
            mask_reg <= (MAXW == CW'(DW)) ? '1 : ((DW'(1) << MAXW) - DW'(1));
        end else if (cfg_we) begin
            w_reg    <= w_next;
            mask_reg <= mask_next;
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // input stage
    logic             in_v_reg;
    mwalu_pkg::item_t in_item_reg, in_item_next;

    always_comb begin
        in_item_next.op     = mwalu_pkg::op_t'(s_tdata[3:0]);
        in_item_next.a      = s_tdata[67:4] & mask_reg;
        in_item_next.b      = s_tdata[131:68] & mask_reg;
        in_item_next.c      = s_tdata[195:132] & mask_reg;
        in_item_next.mask   = mask_reg;
        in_item_next.w      = w_reg;
        in_item_next.b_zero = ((s_tdata[131:68] & mask_reg) == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (en) begin
            in_v_reg <= s_tvalid;
        end
        if (en) begin
            in_item_reg <= in_item_next;
        end
    end

    logic             dv;
    mwalu_pkg::item_t d_item;
    logic [DW-1:0]    d_quot;
    logic [DW-1:0]    d_rem;
    logic [CW-1:0]    d_cnt;

    mwalu_divpipe #(
        .DEPTH (MAX_WIDTH)
    ) u_divpipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_v_reg),
        .in_item   (in_item_reg),
        .out_valid (dv),
        .out_item  (d_item),
        .out_quot  (d_quot),
        .out_rem   (d_rem),
        .out_cnt   (d_cnt)
    );

    // partial product stage, all non-multiply results settle here
    logic                  p_v_reg;
    mwalu_pkg::op_t        p_op_reg;
    mwalu_pkg::status_t    p_st_reg, p_st_next;
    logic [DW-1:0]         p_mask_reg;
    logic [DW-1:0]         p_alt_reg, p_alt_next;
    logic [2*HW-1:0]       p_ll_reg;
    logic [HW-1:0]         p_cross_reg;
    logic [2*HW-1:0]       pp_hl, pp_lh;
    logic [CW-1:0]         inv_cnt;
    logic [DW-1:0]         a, b, c;

    assign a       = d_item.a;
    assign b       = d_item.b;
    assign c       = d_item.c;
    assign inv_cnt = d_item.w - d_cnt;
    assign pp_hl   = a[DW-1:HW] * b[HW-1:0];
    assign pp_lh   = a[HW-1:0] * b[DW-1:HW];

    always_comb begin
        p_st_next = mwalu_pkg::ST_OK;
        case (d_item.op)
            mwalu_pkg::OP_NOT:  p_alt_next = ~a;
            mwalu_pkg::OP_NEG:  p_alt_next = DW'(0) - a;
            mwalu_pkg::OP_AND:  p_alt_next = a & b;
            mwalu_pkg::OP_OR:   p_alt_next = a | b;
            mwalu_pkg::OP_XOR:  p_alt_next = a ^ b;
            mwalu_pkg::OP_ADD:  p_alt_next = a + b;
            mwalu_pkg::OP_SUB:  p_alt_next = a - b;
            mwalu_pkg::OP_DIV: begin
                p_alt_next = d_item.b_zero ? '0 : d_quot;
                if (d_item.b_zero) begin
                    p_st_next = mwalu_pkg::ST_DIV0;
                end
            end
            mwalu_pkg::OP_MOD: begin
                p_alt_next = d_item.b_zero ? '0 : d_rem;
                if (d_item.b_zero) begin
                    p_st_next = mwalu_pkg::ST_MOD0;
                end
            end
            mwalu_pkg::OP_SHL:  p_alt_next = a << d_cnt;
            mwalu_pkg::OP_SHR:  p_alt_next = a >> d_cnt;
            mwalu_pkg::OP_ROTL: p_alt_next = (d_cnt == '0) ? a :
                                             ((a << d_cnt) | (a >> inv_cnt));
            mwalu_pkg::OP_ROTR: p_alt_next = (d_cnt == '0) ? a :
                                             ((a >> d_cnt) | (a << inv_cnt));
            mwalu_pkg::OP_CH:   p_alt_next = (a & b) ^ (~a & c);
            mwalu_pkg::OP_MAJ:  p_alt_next = (a & b) ^ (a & c) ^ (b & c);
            default:            p_alt_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (en) begin
            p_v_reg <= dv;
        end
        if (en) begin
            p_op_reg    <= d_item.op;
            p_st_reg    <= p_st_next;
            p_mask_reg  <= d_item.mask;
            p_alt_reg   <= p_alt_next;
            p_ll_reg    <= a[HW-1:0] * b[HW-1:0];
            p_cross_reg <= pp_hl[HW-1:0] + pp_lh[HW-1:0];
        end
    end

    // result register
    logic               o_v_reg;
    logic [DW-1:0]      o_val_reg, o_val_next;
    mwalu_pkg::status_t o_st_reg;
    logic [DW-1:0]      mul_val;

    assign mul_val    = p_ll_reg + {p_cross_reg, {HW{1'b0}}};
    assign o_val_next = ((p_op_reg == mwalu_pkg::OP_MUL) ? mul_val : p_alt_reg) & p_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_v_reg <= 1'b0;
        end else if (en) begin
            o_v_reg <= p_v_reg;
        end
        if (en) begin
            o_val_reg <= o_val_next;
            o_st_reg  <= p_st_reg;
        end
    end

    assign m_tvalid = o_v_reg;
    assign m_tdata  = {6'b0, o_st_reg, o_val_reg};

    `MWALU_ASSERT_IMPLY(a_err_zero, aclk, aresetn, m_tvalid && (o_st_reg != mwalu_pkg::ST_OK), o_val_reg == '0, "error result not zero")
    `MWALU_ASSERT_IMPLY(a_in_mask, aclk, aresetn, m_tvalid, (o_val_reg & ~mask_reg) == '0, "result wider than width")
    `MWALU_ASSERT_IMPLY(a_ready_rule, aclk, aresetn, 1'b1, s_tready == (!m_tvalid || m_tready), "ready out of step with output stage")

endmodule

@@ design/mwalu_divpipe.sv @@
// restoring divide pipeline, one quotient bit per stage, with a second lane
// that reduces the shift count modulo the width; uses mwalu_pkg
`include "masked_width_integer_alu_top_assert.svh"

module mwalu_divpipe #(
    parameter int DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  mwalu_pkg::item_t                in_item,
    output logic                            out_valid,
    output mwalu_pkg::item_t                out_item,
    output logic [mwalu_pkg::DATA_W-1:0]    out_quot,
    output logic [mwalu_pkg::DATA_W-1:0]    out_rem,
    output logic [mwalu_pkg::WID_W-1:0]     out_cnt
);

    localparam int DW = mwalu_pkg::DATA_W;
    localparam int CW = mwalu_pkg::WID_W;

    logic             valid_reg [DEPTH];
    mwalu_pkg::item_t item_reg  [DEPTH];
    logic [DW-1:0]    quot_reg  [DEPTH];
    logic [DW-1:0]    rem_reg   [DEPTH];
    logic [CW-1:0]    cnt_reg   [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_stage
        localparam int BI = DEPTH - 1 - k;

        logic             v_in;
        mwalu_pkg::item_t item_in;
        logic [DW-1:0]    quot_in;
        logic [DW-1:0]    rem_in;
        logic [CW-1:0]    cnt_in;
        logic [DW:0]      trial;
        logic [DW:0]      diff;
        logic             ge;
        logic [CW:0]      ctrial;
        logic [CW:0]      cdiff;
        logic             cge;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign item_in = in_item;
            assign quot_in = '0;
            assign rem_in  = '0;
            assign cnt_in  = '0;
        end else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign item_in = item_reg[k-1];
            assign quot_in = quot_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign cnt_in  = cnt_reg[k-1];
        end

        // bring down the next dividend bit, subtract when it fits
        assign trial  = {rem_in, item_in.a[BI]};
        assign diff   = trial - {1'b0, item_in.b};
        assign ge     = (trial >= {1'b0, item_in.b});
        // same step on the count lane, divisor is the width
        assign ctrial = {cnt_in, item_in.b[BI]};
        assign cdiff  = ctrial - {1'b0, item_in.w};
        assign cge    = (ctrial >= {1'b0, item_in.w});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
            if (en) begin
                item_reg[k] <= item_in;
                quot_reg[k] <= {quot_in[DW-2:0], ge};
                rem_reg[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                cnt_reg[k]  <= cge ? cdiff[CW-1:0] : ctrial[CW-1:0];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_item  = item_reg[DEPTH-1];
    assign out_quot  = quot_reg[DEPTH-1];
    assign out_rem   = rem_reg[DEPTH-1];
    assign out_cnt   = cnt_reg[DEPTH-1];

    `MWALU_ASSERT_IMPLY(a_cnt_below_width, aclk, aresetn, out_valid, out_cnt < out_item.w, "shift count not reduced below width")
    `MWALU_ASSERT_NEXT(a_enter_first, aclk, aresetn, en && in_valid, valid_reg[0], "item lost at first divide stage")
    `MWALU_ASSERT_IMPLY(a_rem_below_div, aclk, aresetn, out_valid && !out_item.b_zero, out_rem < out_item.b, "remainder not below divisor")

endmodule
